@@ hdl/npcm_pkg.sv @@
// Shared types, constants and helper functions for the nearest palette color match block.
// Depends on nothing; every other file in hdl imports it.
package npcm_pkg;

    localparam int COMP_W  = 8;
    localparam int ENTRY_W = 3 * COMP_W;
    localparam int SQ_W    = 2 * COMP_W;
    // Three squared 8-bit differences sum to at most 195075, which fits in 18 bits.
    localparam int DIST_W  = 18;

    localparam logic [COMP_W-1:0] ALPHA_OPAQUE      = 8'hFF;
    localparam logic [COMP_W-1:0] ALPHA_TRANSPARENT = 8'h00;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } npcm_state_t;

    // Control into the distance unit: clear restarts the search, valid marks an entry.
    typedef struct packed {
        logic clear;
        logic valid;
    } npcm_ctl_t;

    // A 5-bit component widened to 8 bits: shift left by three and add 4.
    function automatic logic [COMP_W-1:0] widen5(input logic [4:0] c5);
        return {c5, 3'b100};
    endfunction

    function automatic logic [COMP_W-1:0] absdiff(input logic [COMP_W-1:0] a,
                                                  input logic [COMP_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ hdl/npcm_dist_unit.sv @@
// Shared distance unit: squares component differences, sums them and keeps the running minimum.
// Depends on npcm_pkg.
module npcm_dist_unit #(
    parameter int IDX_W = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  npcm_pkg::npcm_ctl_t      ctl,
    input  logic [IDX_W-1:0]         idx,
    input  logic [npcm_pkg::ENTRY_W-1:0] entry,
    input  logic [npcm_pkg::COMP_W-1:0]  ref_r,
    input  logic [npcm_pkg::COMP_W-1:0]  ref_g,
    input  logic [npcm_pkg::COMP_W-1:0]  ref_b,
    output logic                     pending,
    output logic [IDX_W-1:0]         best_idx
);
    import npcm_pkg::*;

    logic              sq_valid_reg;
    logic [IDX_W-1:0]  sq_idx_reg;
    logic [SQ_W-1:0]   sq_r_reg;
    logic [SQ_W-1:0]   sq_g_reg;
    logic [SQ_W-1:0]   sq_b_reg;
    logic [COMP_W-1:0] d_r;
    logic [COMP_W-1:0] d_g;
    logic [COMP_W-1:0] d_b;
    logic [DIST_W-1:0] dist_sum;
    logic [DIST_W-1:0] best_d_reg;
    logic [DIST_W-1:0] best_d_next;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [IDX_W-1:0]  best_idx_next;

    assign d_r = absdiff(ref_r, entry[COMP_W-1:0]);
    assign d_g = absdiff(ref_g, entry[2*COMP_W-1:COMP_W]);
    assign d_b = absdiff(ref_b, entry[3*COMP_W-1:2*COMP_W]);

    // First stage: one square per component, registered.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sq_valid_reg <= 1'b0;
        end
        else begin
            sq_valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk) begin
        sq_idx_reg <= idx;
        sq_r_reg   <= SQ_W'(d_r * d_r);
        sq_g_reg   <= SQ_W'(d_g * d_g);
        sq_b_reg   <= SQ_W'(d_b * d_b);
    end

    // Second stage: sum and compare. A strict less-than keeps the lowest index on ties.
    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    always_comb begin
        priority if (ctl.clear) begin
            best_d_next   = '1;
            best_idx_next = '0;
        end
        else if (sq_valid_reg && (dist_sum < best_d_reg)) begin
            best_d_next   = dist_sum;
            best_idx_next = sq_idx_reg;
        end
        else begin
            best_d_next   = best_d_reg;
            best_idx_next = best_idx_reg;
        end
    end

    always_ff @(posedge clk) begin
        best_d_reg   <= best_d_next;
        best_idx_reg <= best_idx_next;
    end

    assign pending  = sq_valid_reg;
    assign best_idx = best_idx_reg;

    a_clear_not_with_valid : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |-> !ctl.valid)
        else $error("distance unit cleared while an entry is presented");

    a_clear_not_while_pending : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |-> !sq_valid_reg)
        else $error("distance unit cleared while a distance is still in flight");

endmodule

@@ hdl/nearest_palette_color_match.sv @@
// Top level of the nearest palette color match block: palette memory, sequencer and result port.
// Depends on npcm_pkg and npcm_dist_unit.
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  ----------------------------------------------
//  command   in         start high, busy low       command, entry_index, red, green, blue, color15
//  result    out        done high for one cycle    packed_color, nearest_index
//
// A write command stores the entry at the accepting edge, and the packed word appears
// with done on the next cycle; busy stays low, so writes can follow every cycle. A match
// visits the palette one entry per cycle through a single memory read port and one
// shared distance unit; busy is high throughout.
// Reset is asynchronous and active low; it clears the sequencer and the result strobe but
// not the palette, whose entries are undefined until written.
// The receiver cannot stall: each result transfer lasts exactly the one cycle done is high.
module nearest_palette_color_match #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [14:0] color15,
    output logic        done,
    output logic [31:0] packed_color,
    output logic [7:0]  nearest_index
);
    import npcm_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PALETTE_ENTRIES - 1);
    localparam logic [8:0]       DEPTH_9   = 9'(PALETTE_ENTRIES);
    localparam logic [7:0]       LAST_IDX8 = 8'(PALETTE_ENTRIES - 1);

    // Sequencer and result registers.
    npcm_state_t       state_reg;
    npcm_state_t       state_next;
    logic [IDX_W-1:0]  addr_reg;
    logic [IDX_W-1:0]  addr_next;
    logic              done_reg;
    logic              done_next;
    logic [31:0]       packed_reg;
    logic [31:0]       packed_next;
    logic [7:0]        nearest_reg;
    logic [7:0]        nearest_next;
    logic [COMP_W-1:0] ref_r_reg;
    logic [COMP_W-1:0] ref_r_next;
    logic [COMP_W-1:0] ref_g_reg;
    logic [COMP_W-1:0] ref_g_next;
    logic [COMP_W-1:0] ref_b_reg;
    logic [COMP_W-1:0] ref_b_next;

    // Palette memory with one write port and one registered read port.
    logic [ENTRY_W-1:0] palette_mem [PALETTE_ENTRIES];
    logic               mem_we;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_valid_reg;
    logic               rd_valid_next;
    logic [IDX_W-1:0]   rd_idx_reg;

    logic               accept;
    logic               in_range;
    npcm_ctl_t          unit_ctl;
    logic               unit_pending;
    logic [IDX_W-1:0]   unit_best_idx;

    assign accept   = start && !busy;
    assign in_range = {1'b0, entry_index} < DEPTH_9;
    assign mem_we   = accept && (command == CMD_WRITE) && in_range;

    always_ff @(posedge clk) begin
        if (mem_we) begin
            palette_mem[entry_index[IDX_W-1:0]] <= {blue, green, red};
        end
        rd_data_reg <= palette_mem[addr_reg];
        rd_idx_reg  <= addr_reg;
    end

    // The sequencer issues one read per cycle during the scan, then waits for the
    // two pipeline stages behind the memory to empty before reporting the winner.
    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        done_next     = 1'b0;
        packed_next   = packed_reg;
        nearest_next  = nearest_reg;
        ref_r_next    = ref_r_reg;
        ref_g_next    = ref_g_reg;
        ref_b_next    = ref_b_reg;
        rd_valid_next = 1'b0;
        unit_ctl      = '{clear: 1'b0, valid: 1'b0};
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (command == CMD_WRITE) begin
                        // The last entry is the transparent one; writes beyond the
                        // palette leave it unchanged and still report opaque alpha.
                        done_next    = 1'b1;
                        nearest_next = '0;
                        if (in_range && (entry_index == LAST_IDX8)) begin
                            packed_next = {ALPHA_TRANSPARENT, blue, green, red};
                        end
                        else begin
                            packed_next = {ALPHA_OPAQUE, blue, green, red};
                        end
                    end
                    else begin
                        ref_r_next     = widen5(color15[4:0]);
                        ref_g_next     = widen5(color15[9:5]);
                        ref_b_next     = widen5(color15[14:10]);
                        addr_next      = '0;
                        unit_ctl.clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_valid_next = 1'b1;
                if (addr_reg == LAST_ADDR) begin
                    state_next = ST_DRAIN;
                end
                else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!rd_valid_reg && !unit_pending) begin
                    done_next    = 1'b1;
                    packed_next  = '0;
                    nearest_next = 8'(unit_best_idx);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        unit_ctl.valid = rd_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            addr_reg     <= '0;
            done_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            done_reg     <= done_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        packed_reg  <= packed_next;
        nearest_reg <= nearest_next;
        ref_r_reg   <= ref_r_next;
        ref_g_reg   <= ref_g_next;
        ref_b_reg   <= ref_b_next;
    end

    npcm_dist_unit #(
        .IDX_W(IDX_W)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (unit_ctl),
        .idx      (rd_idx_reg),
        .entry    (rd_data_reg),
        .ref_r    (ref_r_reg),
        .ref_g    (ref_g_reg),
        .ref_b    (ref_b_reg),
        .pending  (unit_pending),
        .best_idx (unit_best_idx)
    );

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign packed_color  = packed_reg;
    assign nearest_index = nearest_reg;

    a_match_goes_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_MATCH)) |=> busy)
        else $error("match accepted but the block did not go busy");

    a_no_result_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result transfer while a match is still running");

    a_read_only_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)))
        else $error("palette read in flight outside a match");

    a_match_result_shape : assert property (@(posedge clk) disable iff (!rst_n)
        (done && (packed_color != 32'd0)) |-> (nearest_index == 8'd0))
        else $error("write result carries a nonzero nearest index");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for nearest_palette_color_match: palette writes and RGB555 nearest-color searches.
// Depends on npcm_pkg and the nearest_palette_color_match RTL, which also needs npcm_dist_unit.
// A scoreboard class predicts every result, and plain tasks drive commands with random gaps.

module tb_top;
    import npcm_pkg::*;

    localparam int ENTRIES       = 256;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    // A match holds busy for the whole palette scan and the pipeline drain behind it.
    localparam int MATCH_LATENCY = ENTRIES + 3;
    localparam int PHASE_ITEMS   = 60;

    // One result as the block reports it.
    typedef struct {
        logic [31:0] packed_color;
        logic [7:0]  nearest_index;
    } palette_result_t;

    // The scoreboard keeps its own copy of the palette. Each accepted command updates that
    // copy and queues the result it must produce; each result strobe is checked against the
    // oldest queued result, in order.
    class palette_scoreboard;
        logic [23:0]     palette [ENTRIES];
        palette_result_t result_q [$];
        int              errors;

        // Exhaustive search over the palette. The square root is left out because it does
        // not change the ordering, and a strict less-than keeps the lowest index on ties.
        function logic [7:0] nearest_entry(logic [14:0] key);
            int         tgt_r;
            int         tgt_g;
            int         tgt_b;
            int         dr;
            int         dg;
            int         db;
            int         sq_dist;
            int         best_dist;
            logic [7:0] best;
            tgt_r     = (int'(key[4:0]) << 3) + 4;
            tgt_g     = (int'(key[9:5]) << 3) + 4;
            tgt_b     = (int'(key[14:10]) << 3) + 4;
            best_dist = 32'h7FFF_FFFF;
            best      = '0;
            for (int k = 0; k < ENTRIES; k++)
            begin
                dr      = tgt_r - int'(palette[k][7:0]);
                dg      = tgt_g - int'(palette[k][15:8]);
                db      = tgt_b - int'(palette[k][23:16]);
                sq_dist = dr * dr + dg * dg + db * db;
                if (sq_dist < best_dist)
                begin
                    best_dist = sq_dist;
                    best      = k[7:0];
                end
            end
            return best;
        endfunction

        function void note_command(logic cmd, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                   logic [7:0] b, logic [14:0] key);
            palette_result_t res;
            if (cmd == CMD_WRITE)
            begin
                // The last entry is the transparent one and reports alpha zero.
                palette[idx]      = {b, g, r};
                res.packed_color  = {(int'(idx) == ENTRIES - 1) ? ALPHA_TRANSPARENT
                                                                : ALPHA_OPAQUE, b, g, r};
                res.nearest_index = '0;
            end
            else
            begin
                res.packed_color  = '0;
                res.nearest_index = nearest_entry(key);
            end
            result_q.push_back(res);
        endfunction

        function void check_result(logic [31:0] pc, logic [7:0] ni);
            palette_result_t exp_res;
            if (result_q.size() == 0)
            begin
                $error("result with no command outstanding: packed_color %h, nearest_index %0d",
                       pc, ni);
                errors++;
                return;
            end
            exp_res = result_q.pop_front();
            if (pc !== exp_res.packed_color)
            begin
                $error("packed_color: expected %h, actual %h", exp_res.packed_color, pc);
                errors++;
            end
            if (ni !== exp_res.nearest_index)
            begin
                $error("nearest_index: expected %0d, actual %0d", exp_res.nearest_index, ni);
                errors++;
            end
        endfunction

        function int pending();
            return result_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        start         = 1'b0;
    logic        busy;
    logic        command       = CMD_WRITE;
    logic [7:0]  entry_index   = '0;
    logic [7:0]  red           = '0;
    logic [7:0]  green         = '0;
    logic [7:0]  blue          = '0;
    logic [14:0] color15       = '0;
    logic        done;
    logic [31:0] packed_color;
    logic [7:0]  nearest_index;

    palette_scoreboard sb = new;

    // Percentage of cycles in which the sender holds start low before a command.
    int          idle_pct;
    // What the stimulus side has written, so that it can aim matches at real entries
    // without racing against the scoreboard's update at the same clock edge.
    logic [23:0] shadow_palette [ENTRIES];

    nearest_palette_color_match #(
        .PALETTE_ENTRIES(ENTRIES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .entry_index  (entry_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .color15      (color15),
        .done         (done),
        .packed_color (packed_color),
        .nearest_index(nearest_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Every input changes only through nonblocking assignments at the rising edge, so the
    // values read here at the edge are the ones the block samples. The result is checked
    // before the new command is noted: a result seen at this edge always belongs to an
    // older command.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(packed_color, nearest_index);
            if (start && !busy)
                sb.note_command(command, entry_index, red, green, blue, color15);
        end
    end

    // The widened value of a 5-bit component: exactly where a match key lands.
    function automatic logic [7:0] level5(logic [4:0] c5);
        return 8'((int'(c5) << 3) + 4);
    endfunction

    // The match key whose widened color lies nearest to a palette entry.
    function automatic logic [14:0] key_of(logic [23:0] rgb);
        return {rgb[23:19], rgb[15:11], rgb[7:3]};
    endfunction

    // Presents one command after a random number of idle cycles and holds it until the
    // transfer happens. Returns at the edge that accepted it.
    task automatic send_item(logic cmd, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b, logic [14:0] key);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        entry_index <= idx;
        red         <= r;
        green       <= g;
        blue        <= b;
        color15     <= key;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // The fields a command does not use still carry random values.
    task automatic send_write(logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        shadow_palette[idx] = {b, g, r};
        send_item(CMD_WRITE, idx, r, g, b, 15'($urandom));
    endtask

    task automatic send_match(logic [14:0] key);
        send_item(CMD_MATCH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), key);
    endtask

    // Holds start low until every outstanding result has arrived. The wait looks at the
    // falling edge, after the monitor has handled the rising one.
    task automatic wait_quiet();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        @(posedge clk);
    endtask

    // One random command. Writes mix arbitrary colors, colors that sit exactly on the
    // match grid, and copies of existing entries so that ties show up; some land on the
    // transparent entry on purpose. Matches either take any key or aim at an entry, now
    // and then with one key bit flipped so the winner is a near miss.
    task automatic random_item();
        logic [7:0]  idx;
        logic [23:0] near;
        logic [14:0] key;
        idx  = ($urandom_range(99) < 5) ? 8'(ENTRIES - 1) : 8'($urandom);
        near = shadow_palette[$urandom_range(ENTRIES - 1)];
        if ($urandom_range(99) < 55)
        begin
            case ($urandom_range(2))
                0: send_write(idx, 8'($urandom), 8'($urandom), 8'($urandom));
                1: send_write(idx, level5(5'($urandom)), level5(5'($urandom)),
                              level5(5'($urandom)));
                default: send_write(idx, near[7:0], near[15:8], near[23:16]);
            endcase
        end
        else if ($urandom_range(1) == 0)
            send_match(15'($urandom));
        else
        begin
            key = key_of(near);
            if ($urandom_range(2) == 0)
                key = key ^ (15'(1) << $urandom_range(14));
            send_match(key);
        end
    endtask

    initial
    begin
        logic [14:0] tie_key;
        logic [14:0] clear_key;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every entry is undefined until written, so the whole palette is filled before
        // the first match. Black sits at the bottom and white at the transparent top.
        idle_pct = 18;
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (k == 0)
                send_write(8'(k), 8'h00, 8'h00, 8'h00);
            else if (k == ENTRIES - 1)
                send_write(8'(k), 8'hFF, 8'hFF, 8'hFF);
            else if ($urandom_range(99) < 30)
                send_write(8'(k), level5(5'($urandom)), level5(5'($urandom)),
                           level5(5'($urandom)));
            else
                send_write(8'(k), 8'($urandom), 8'($urandom), 8'($urandom));
        end

        // Directed part: key extremes and each pure primary.
        send_match(15'h0000);
        send_match(15'h7FFF);
        send_match(15'h001F);
        send_match(15'h03E0);
        send_match(15'h7C00);

        // Writes at the entry extremes and the middle entry, one of them to the transparent entry.
        send_write(8'(ENTRIES - 1), 8'h12, 8'h34, 8'h56);
        send_write(8'(ENTRIES - 2), 8'hFF, 8'h00, 8'hFF);
        send_write(8'h00, 8'h00, 8'hFF, 8'h00);
        send_write(8'h80, 8'h80, 8'h80, 8'h80);

        // Three entries hit the same key exactly; the lowest of them must win the tie.
        tie_key = 15'h1234;
        send_write(8'd7, level5(tie_key[4:0]), level5(tie_key[9:5]), level5(tie_key[14:10]));
        send_write(8'd100, level5(tie_key[4:0]), level5(tie_key[9:5]),
                   level5(tie_key[14:10]));
        send_write(8'd200, level5(tie_key[4:0]), level5(tie_key[9:5]),
                   level5(tie_key[14:10]));
        send_match(tie_key);

        // The transparent entry takes part in the search like any other.
        clear_key = 15'h5555;
        send_write(8'(ENTRIES - 1), level5(clear_key[4:0]), level5(clear_key[9:5]),
                   level5(clear_key[14:10]));
        send_match(clear_key);
        send_write(8'(ENTRIES - 1), 8'hFF, 8'hFF, 8'hFF);
        send_match(15'h7FFF);
        send_match(15'h0000);
        wait_quiet();

        // Random part in three stretches: the sender idles rarely, often, then never.
        // Now and then, and after each stretch, the sender waits until nothing is owed.
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 18 : (phase == 1) ? 63 : 0;
            repeat (PHASE_ITEMS)
            begin
                random_item();
                if ($urandom_range(99) < 2)
                    wait_quiet();
            end
            wait_quiet();
        end

        // Allow a full match time for any stray result strobe to show up.
        repeat (MATCH_LATENCY + 8) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // A correct run stays far below this bound even if every command were a match.
    initial
    begin
        #(CLK_PERIOD * 1_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
